FILE: rtl/v3n_pkg.sv
// v3n_pkg: shared types and widths for the 3D vector normalizer.
// No dependencies; every other file imports it.
package v3n_pkg;

    localparam int DATA_W = 32;
    localparam int SQ_W   = 64;

    typedef logic signed [DATA_W-1:0] comp_t;
    typedef logic        [DATA_W-1:0] mag_t;
    typedef logic        [SQ_W-1:0]   sq_t;

endpackage

FILE: rtl/v3n_if.sv
// v3n_if: valid/ready channels carrying one input vector and one unit vector.
// Depends on v3n_pkg.
interface v3n_in_if import v3n_pkg::*; ();
    logic  valid;
    logic  ready;
    comp_t vec_x;
    comp_t vec_y;
    comp_t vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface v3n_out_if import v3n_pkg::*; ();
    logic  valid;
    logic  ready;
    comp_t unit_x;
    comp_t unit_y;
    comp_t unit_z;
    logic  zero_length;

    modport source (output valid, output unit_x, output unit_y, output unit_z,
                    output zero_length, input ready);
    modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                    input zero_length, output ready);
endinterface

FILE: rtl/v3n_sumsq.sv
// v3n_sumsq: magnitudes, squares and sum of squares, three pipeline stages.
// Depends on v3n_pkg.
module v3n_sumsq import v3n_pkg::*;
(
    input  logic            clk,
    input  logic [2:0]      en,
    input  comp_t           vec_x,
    input  comp_t           vec_y,
    input  comp_t           vec_z,
    output logic [2:0][SQ_W-1:0] sq,
    output sq_t             sum,
    output logic            zero,
    output logic [2:0]      neg
);

    comp_t           comp [3];
    mag_t            mag_reg [3];
    logic [2:0]      neg0_reg;
    logic [2:0]      neg1_reg;
    logic [2:0]      neg2_reg;
    sq_t             sq1_reg [3];
    sq_t             sq2_reg [3];
    sq_t             sum_next;
    sq_t             sum_reg;
    logic            zero_reg;

    assign comp[0] = vec_x;
    assign comp[1] = vec_y;
    assign comp[2] = vec_z;

    // the sum cannot overflow: three squares of at most 2^62 each
    assign sum_next = sq1_reg[0] + sq1_reg[1] + sq1_reg[2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (en[0])
            begin
                neg0_reg[i] <= comp[i][DATA_W-1];
                mag_reg[i]  <= comp[i][DATA_W-1] ? mag_t'(~comp[i] + 1'b1) : mag_t'(comp[i]);
            end
            if (en[1])
            begin
                neg1_reg[i] <= neg0_reg[i];
                sq1_reg[i]  <= sq_t'(mag_reg[i]) * sq_t'(mag_reg[i]);
            end
            if (en[2])
            begin
                neg2_reg[i] <= neg1_reg[i];
                sq2_reg[i]  <= sq1_reg[i];
            end
        end
        if (en[2])
        begin
            sum_reg  <= sum_next;
            zero_reg <= (sum_next == '0);
        end
    end

    assign sq[0] = sq2_reg[0];
    assign sq[1] = sq2_reg[1];
    assign sq[2] = sq2_reg[2];
    assign sum   = sum_reg;
    assign zero  = zero_reg;
    assign neg   = neg2_reg;

endmodule

FILE: rtl/v3n_lane.sv
// v3n_lane: restoring square-root-of-ratio search for one component,
// one quotient bit per stage. Depends on v3n_pkg.
module v3n_lane import v3n_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 30
)
(
    input  logic                   clk,
    input  logic [OUT_FRAC_BITS:0] en,
    input  sq_t                    sq,
    input  sq_t                    sum,
    input  logic                   neg,
    output logic [OUT_FRAC_BITS:0] q,
    output logic                   q_neg
);

    localparam int NST = OUT_FRAC_BITS + 1;
    localparam int RW  = SQ_W + 2 * OUT_FRAC_BITS + 4;
    localparam int AW  = SQ_W + OUT_FRAC_BITS + 1;
    localparam int QW  = OUT_FRAC_BITS + 1;

    // residual = sq*2^(2F) - q^2*S, acc = q*S
    logic [RW-1:0] res_reg [NST];
    logic [AW-1:0] acc_reg [NST];
    logic [QW-1:0] q_reg   [NST];
    sq_t           sum_reg [NST];
    logic          neg_reg [NST];

    for (genvar j = 0; j < NST; j++)
    begin : g_stage
        localparam int B = OUT_FRAC_BITS - j;
        logic [RW-1:0] res_in;
        logic [AW-1:0] acc_in;
        logic [QW-1:0] q_in;
        sq_t           sum_in;
        logic          neg_in;
        logic [RW-1:0] cand;
        logic          take;

        if (j == 0)
        begin : g_first
            assign res_in = RW'(sq) << (2 * OUT_FRAC_BITS);
            assign acc_in = '0;
            assign q_in   = '0;
            assign sum_in = sum;
            assign neg_in = neg;
        end
        else
        begin : g_next
            assign res_in = res_reg[j-1];
            assign acc_in = acc_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign sum_in = sum_reg[j-1];
            assign neg_in = neg_reg[j-1];
        end

        // (q + 2^B)^2 * S - q^2 * S
        assign cand = (RW'(acc_in) << (B + 1)) + (RW'(sum_in) << (2 * B));
        assign take = (cand <= res_in);

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                res_reg[j] <= take ? (res_in - cand) : res_in;
                acc_reg[j] <= take ? AW'(acc_in + (AW'(sum_in) << B)) : acc_in;
                q_reg[j]   <= take ? (q_in | (QW'(1) << B)) : q_in;
                sum_reg[j] <= sum_in;
                neg_reg[j] <= neg_in;
            end
        end
    end

    assign q     = q_reg[NST-1];
    assign q_neg = neg_reg[NST-1];

endmodule

FILE: rtl/v3n_merge.sv
// v3n_merge: output register; clamps, signs and zeroes the lane quotients.
// Depends on v3n_pkg.
module v3n_merge import v3n_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 30
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [2:0][OUT_FRAC_BITS:0] q,
    input  logic [2:0]                  neg,
    input  logic                        zero,
    output comp_t                       unit_x,
    output comp_t                       unit_y,
    output comp_t                       unit_z,
    output logic                        zero_length
);

    localparam logic [OUT_FRAC_BITS:0] ONE = (OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS;

    comp_t unit_next [3];
    comp_t unit_reg  [3];
    logic  zero_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [OUT_FRAC_BITS:0] qc;
            comp_t                  m;
            qc = (q[i] > ONE) ? ONE : q[i];
            m  = comp_t'(qc);
            if (zero)
                unit_next[i] = '0;
            else
                unit_next[i] = neg[i] ? -m : m;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                unit_reg[i] <= unit_next[i];
            end
            zero_reg <= zero;
        end
    end

    assign unit_x      = unit_reg[0];
    assign unit_y      = unit_reg[1];
    assign unit_z      = unit_reg[2];
    assign zero_length = zero_reg;

endmodule

FILE: rtl/vector3_normalize_top.sv
// vector3_normalize_top: 3D vector normalizer, Q15.16 in, Q1.30 out.
// Depends on v3n_pkg, v3n_if, v3n_sumsq, v3n_lane, v3n_merge.
//
//   channel   dir   payload                                  transfer
//   vec_in    in    vec_x, vec_y, vec_z                      valid & ready
//   unit_out  out   unit_x, unit_y, unit_z, zero_length      valid & ready
//
// One vector per cycle sustained while unit_out is not stalled.
// Three lanes each resolve one quotient bit per stage, so the lane depth
// OUT_FRAC_BITS + 1 dominates the latency.
// Reset clears only the stage valid bits.
// Each stage holds when its successor is full and stalled; empty stages
// still fill, so input keeps flowing until the pipe is full.
module vector3_normalize_top import v3n_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 30
)
(
    input  logic        clk,
    input  logic        rst_n,
    v3n_in_if.sink      vec_in,
    v3n_out_if.source   unit_out
);

    localparam int LANE0 = 3;
    localparam int NL    = OUT_FRAC_BITS + 1;
    localparam int NS    = LANE0 + NL + 1;

    logic [NS-1:0]          valid_reg;
    logic [NS-1:0]          valid_next;
    logic [NS:0]            rdy;
    logic [NS-1:0]          en;

    logic [2:0][SQ_W-1:0]        sq;
    sq_t                         sum;
    logic                        zero;
    logic [2:0]                  neg;
    logic [2:0][OUT_FRAC_BITS:0] q;
    logic [2:0]                  q_neg;
    logic                        zero_line_reg [NL];

    // a stage can load when empty or when its contents move on
    always_comb
    begin
        rdy[NS] = unit_out.ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        en = rdy[NS-1:0];
        valid_next[0] = en[0] ? vec_in.valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
                valid_next[k] = valid_reg[k-1];
            else
                valid_next[k] = valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign vec_in.ready   = en[0];
    assign unit_out.valid = valid_reg[NS-1];

    v3n_sumsq u_sumsq
    (
        .clk   (clk),
        .en    (en[2:0]),
        .vec_x (vec_in.vec_x),
        .vec_y (vec_in.vec_y),
        .vec_z (vec_in.vec_z),
        .sq    (sq),
        .sum   (sum),
        .zero  (zero),
        .neg   (neg)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        v3n_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane
        (
            .clk   (clk),
            .en    (en[LANE0 +: NL]),
            .sq    (sq[i]),
            .sum   (sum),
            .neg   (neg[i]),
            .q     (q[i]),
            .q_neg (q_neg[i])
        );
    end

    // carry the zero-length flag alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en[LANE0])
            zero_line_reg[0] <= zero;
        for (int j = 1; j < NL; j++)
        begin
            if (en[LANE0 + j])
                zero_line_reg[j] <= zero_line_reg[j-1];
        end
    end

    v3n_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge
    (
        .clk         (clk),
        .en          (en[NS-1]),
        .q           (q),
        .neg         (q_neg),
        .zero        (zero_line_reg[NL-1]),
        .unit_x      (unit_out.unit_x),
        .unit_y      (unit_out.unit_y),
        .unit_z      (unit_out.unit_z),
        .zero_length (unit_out.zero_length)
    );

endmodule

FILE: rtl/v3n_check.sv
// v3n_check: port-level assertions for vector3_normalize_top, bound in below.
// Depends on v3n_pkg.
module v3n_check import v3n_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 30
)
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input comp_t unit_x,
    input comp_t unit_y,
    input comp_t unit_z,
    input logic  zero_length
);

    localparam comp_t ONE = comp_t'(1) <<< OUT_FRAC_BITS;

    logic [7:0] pend_reg;
    logic [7:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_valid && in_ready)
            pend_next = pend_next + 8'd1;
        if (out_valid && out_ready)
            pend_next = pend_next - 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 8'd0)
        else $error("result without an accepted vector");

    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
        else $error("zero-length result with nonzero components");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_x <= ONE && unit_x >= -ONE && unit_y <= ONE
                      && unit_y >= -ONE && unit_z <= ONE && unit_z >= -ONE)
        else $error("unit component beyond one");

endmodule

bind vector3_normalize_top v3n_check #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_v3n_check
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (vec_in.valid),
    .in_ready    (vec_in.ready),
    .out_valid   (unit_out.valid),
    .out_ready   (unit_out.ready),
    .unit_x      (unit_out.unit_x),
    .unit_y      (unit_out.unit_y),
    .unit_z      (unit_out.unit_z),
    .zero_length (unit_out.zero_length)
);
